// ===== src/mve_pkg.sv =====
package mve_pkg;

  typedef enum logic [3:0] {
    FUNC_MAP     = 4'd0,
    FUNC_STR     = 4'd1,
    FUNC_FIXINT  = 4'd2,
    FUNC_I8      = 4'd3,
    FUNC_U8      = 4'd4,
    FUNC_I16     = 4'd5,
    FUNC_U16     = 4'd6,
    FUNC_I32     = 4'd7,
    FUNC_U32     = 4'd8,
    FUNC_F32     = 4'd9,
    FUNC_BIN8    = 4'd10,
    FUNC_BIN16   = 4'd11,
    FUNC_PAYLOAD = 4'd12,
    FUNC_SETPOS  = 4'd13
  } func_t;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_BAD   = 2'd1;
  localparam logic [1:0] STATUS_SHORT = 2'd2;

  localparam logic [7:0] HDR_MAP    = 8'h80;
  localparam logic [7:0] HDR_STR    = 8'hA0;
  localparam logic [7:0] HDR_I8     = 8'hD0;
  localparam logic [7:0] HDR_U8     = 8'hCC;
  localparam logic [7:0] HDR_I16    = 8'hD1;
  localparam logic [7:0] HDR_U16    = 8'hCD;
  localparam logic [7:0] HDR_I32    = 8'hD2;
  localparam logic [7:0] HDR_U32    = 8'hCE;
  localparam logic [7:0] HDR_F32    = 8'hCA;
  localparam logic [7:0] HDR_BIN8   = 8'hC4;
  localparam logic [7:0] HDR_BIN16  = 8'hC5;
  localparam logic [7:0] FIXINT_MSK = 8'h7F;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  typedef struct packed {
    logic [4:0][7:0] bytes;
    logic [2:0]      count;
    logic [15:0]     addr;
    logic            emit;
    logic [1:0]      status;
  } cmd_t;

endpackage

// ===== src/msgpack_value_encoder_top.sv =====
// MessagePack value encoder.
// Input channel: drive in_func and in_value with in_push high; the item is taken
// at a clock edge where in_full is low. One item can be taken every cycle until
// the internal command queue of four entries fills.
// Result channel: while out_empty is low, the oldest result is on the out_ ports
// and is taken at a clock edge with out_pop high. Each item gives one result per
// encoded byte (one to five), or a single result without a byte for an error or
// a position change; out_last marks the final result of an item.
// The first result of an item passes through the command queue and is registered
// in the output stage. The back end emits one result per cycle while out_pop is
// high, so an item of N bytes occupies it for N results.
// The capacity register is written through cfg_valid and cfg_data; cfg_ready is
// always high. The user must write it only while the block is idle; the block does not enforce this.
// Reset clears the write position, message length and owed payload count and
// sets the capacity to 65535. When the receiver stalls, results wait in the
// output stage and the queue, and in_full rises once the queue is full.
module msgpack_value_encoder_top #(
  parameter int MAX_BUFFER_BYTES = 65535
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [3:0]  in_func,
  input  logic [31:0] in_value,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [7:0]  out_data_byte,
  output logic [15:0] out_byte_address,
  output logic        out_byte_valid,
  output logic [1:0]  out_status,
  output logic        out_last,
  output logic [15:0] out_message_length,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);
  import mve_pkg::*;

  cmd_t push_cmd, pop_cmd;
  logic q_push, q_full, q_pop, q_empty;

  mve_front #(
    .MAX_BUFFER_BYTES(MAX_BUFFER_BYTES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_func  (in_func),
    .in_value (in_value),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .q_push   (q_push),
    .q_cmd    (push_cmd),
    .q_full   (q_full)
  );

  mve_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_cmd(push_cmd),
    .full    (q_full),
    .pop     (q_pop),
    .pop_cmd (pop_cmd),
    .empty   (q_empty)
  );

  mve_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_cmd             (pop_cmd),
    .q_empty           (q_empty),
    .q_pop             (q_pop),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_data_byte     (out_data_byte),
    .out_byte_address  (out_byte_address),
    .out_byte_valid    (out_byte_valid),
    .out_status        (out_status),
    .out_last          (out_last),
    .out_message_length(out_message_length)
  );

endmodule

// ===== src/mve_front.sv =====
module mve_front #(
  parameter int MAX_BUFFER_BYTES = 65535
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_push,
  output logic         in_full,
  input  logic [3:0]   in_func,
  input  logic [31:0]  in_value,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [15:0]  cfg_data,
  output logic         q_push,
  output mve_pkg::cmd_t q_cmd,
  input  logic         q_full
);
  import mve_pkg::*;

  localparam logic [15:0] MaxBytes = 16'(MAX_BUFFER_BYTES);

  logic [15:0] capacity_r, capacity_nxt;
  logic [15:0] pos_r, pos_nxt;
  logic [15:0] owed_r, owed_nxt;

  logic [15:0] cap;
  logic [16:0] need;
  logic [2:0]  count;
  logic [4:0][7:0] bytes;
  logic bad, setpos, sets_owed, takes_payload, short;
  logic accept;

  assign cfg_ready = 1'b1;
  assign in_full   = q_full;
  assign accept    = in_push && !q_full;
  assign q_push    = accept;
  assign cap       = (capacity_r < MaxBytes) ? capacity_r : MaxBytes;

  always_comb begin
    bad           = 1'b0;
    setpos        = 1'b0;
    sets_owed     = 1'b0;
    takes_payload = 1'b0;
    bytes         = '0;
    count         = 3'd1;
    need          = 17'd1;
    unique case (in_func)
      FUNC_MAP: begin
        bad      = |in_value[31:4];
        bytes[0] = HDR_MAP | {4'h0, in_value[3:0]};
      end
      FUNC_STR: begin
        bad       = |in_value[31:5];
        bytes[0]  = HDR_STR | {3'h0, in_value[4:0]};
        need      = 17'd1 + {12'h0, in_value[4:0]};
        sets_owed = 1'b1;
      end
      FUNC_FIXINT: begin
        bytes[0] = in_value[7:0] & FIXINT_MSK;
      end
      FUNC_I8, FUNC_U8: begin
        bytes[0] = (in_func == FUNC_I8) ? HDR_I8 : HDR_U8;
        bytes[1] = in_value[7:0];
        count    = 3'd2;
        need     = 17'd2;
      end
      FUNC_I16, FUNC_U16: begin
        bytes[0] = (in_func == FUNC_I16) ? HDR_I16 : HDR_U16;
        bytes[1] = in_value[15:8];
        bytes[2] = in_value[7:0];
        count    = 3'd3;
        need     = 17'd3;
      end
      FUNC_I32, FUNC_U32, FUNC_F32: begin
        bytes[0] = (in_func == FUNC_I32) ? HDR_I32 :
                   (in_func == FUNC_U32) ? HDR_U32 : HDR_F32;
        bytes[1] = in_value[31:24];
        bytes[2] = in_value[23:16];
        bytes[3] = in_value[15:8];
        bytes[4] = in_value[7:0];
        count    = 3'd5;
        need     = 17'd5;
      end
      FUNC_BIN8: begin
        bad       = |in_value[31:8];
        bytes[0]  = HDR_BIN8;
        bytes[1]  = in_value[7:0];
        count     = 3'd2;
        need      = 17'd2 + {9'h0, in_value[7:0]};
        sets_owed = 1'b1;
      end
      FUNC_BIN16: begin
        bad       = |in_value[31:16];
        bytes[0]  = HDR_BIN16;
        bytes[1]  = in_value[15:8];
        bytes[2]  = in_value[7:0];
        count     = 3'd3;
        need      = 17'd3 + {1'b0, in_value[15:0]};
        sets_owed = 1'b1;
      end
      FUNC_PAYLOAD: begin
        bad           = (owed_r == 16'd0);
        bytes[0]      = in_value[7:0];
        takes_payload = 1'b1;
      end
      FUNC_SETPOS: begin
        bad    = (in_value >= {16'h0, cap});
        setpos = 1'b1;
      end
      default: begin
        bad = 1'b1;
      end
    endcase
  end

  assign short = ({2'b00, pos_r} + {1'b0, need}) >= {2'b00, cap};

  always_comb begin
    q_cmd        = '0;
    q_cmd.count  = 3'd1;
    q_cmd.addr   = pos_r;
    q_cmd.status = STATUS_OK;
    pos_nxt      = pos_r;
    owed_nxt     = owed_r;
    if (bad) begin
      q_cmd.status = STATUS_BAD;
    end else if (setpos) begin
      q_cmd.addr = in_value[15:0];
      if (accept) begin
        pos_nxt = in_value[15:0];
      end
    end else if (short) begin
      q_cmd.status = STATUS_SHORT;
    end else begin
      q_cmd.emit  = 1'b1;
      q_cmd.bytes = bytes;
      q_cmd.count = count;
      if (accept) begin
        pos_nxt = pos_r + {13'h0, count};
        if (sets_owed) begin
          owed_nxt = in_value[15:0];
        end else if (takes_payload) begin
          owed_nxt = owed_r - 16'd1;
        end
      end
    end
  end

  assign capacity_nxt = (cfg_valid && cfg_ready) ? cfg_data : capacity_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= 16'hFFFF;
      pos_r      <= '0;
      owed_r     <= '0;
    end else begin
      capacity_r <= capacity_nxt;
      pos_r      <= pos_nxt;
      owed_r     <= owed_nxt;
    end
  end

endmodule

// ===== src/mve_queue.sv =====
module mve_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  mve_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output mve_pkg::cmd_t pop_cmd,
  output logic          empty
);
  import mve_pkg::*;

  cmd_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push, do_pop;

  assign full    = (count_r == QCNT_W'(QDEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_cmd = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== src/mve_back.sv =====
module mve_back (
  input  logic          clk,
  input  logic          rst_n,
  input  mve_pkg::cmd_t q_cmd,
  input  logic          q_empty,
  output logic          q_pop,
  output logic          out_empty,
  input  logic          out_pop,
  output logic [7:0]    out_data_byte,
  output logic [15:0]   out_byte_address,
  output logic          out_byte_valid,
  output logic [1:0]    out_status,
  output logic          out_last,
  output logic [15:0]   out_message_length
);
  import mve_pkg::*;

  cmd_t        cur_r, cur_nxt;
  logic        cur_valid_r, cur_valid_nxt;
  logic [15:0] length_r, length_nxt;
  logic [15:0] length_after;
  logic        take;

  assign out_empty          = !cur_valid_r;
  assign out_data_byte      = cur_r.bytes[0];
  assign out_byte_address   = cur_r.addr;
  assign out_byte_valid     = cur_r.emit;
  assign out_status         = cur_r.status;
  assign out_last           = (cur_r.count == 3'd1);
  assign length_after       = (cur_r.emit && length_r != 16'hFFFF) ? length_r + 16'd1
                                                                    : length_r;
  assign out_message_length = length_after;

  assign take  = cur_valid_r && out_pop;
  assign q_pop = !q_empty && (!cur_valid_r || (take && out_last));

  always_comb begin
    cur_nxt       = cur_r;
    cur_valid_nxt = cur_valid_r;
    length_nxt    = take ? length_after : length_r;
    if (q_pop) begin
      cur_nxt       = q_cmd;
      cur_valid_nxt = 1'b1;
    end else if (take) begin
      if (out_last) begin
        cur_valid_nxt = 1'b0;
      end else begin
        cur_nxt.bytes = {8'h00, cur_r.bytes[4:1]};
        cur_nxt.addr  = cur_r.addr + 16'd1;
        cur_nxt.count = cur_r.count - 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      length_r    <= '0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      length_r    <= length_nxt;
    end
  end

endmodule
